// ===== rtl/first_fit_page_allocator_top_assert.svh =====
`ifndef FIRST_FIT_PAGE_ALLOCATOR_TOP_ASSERT_SVH
`define FIRST_FIT_PAGE_ALLOCATOR_TOP_ASSERT_SVH

// Checks that an antecedent in one cycle implies a consequent in the same cycle.
`define FFPA_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Checks that an antecedent in one cycle implies a consequent in the next cycle.
`define FFPA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/ffpa_pkg.sv =====
package ffpa_pkg;

  localparam int FFPA_PAGES = 4096;
  localparam int PAGE_SHIFT = 12;
  localparam int NEED_W = 32 - PAGE_SHIFT;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAP_BYTES = 1'd1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_HEAP   = 3'd1,
    ST_NO_SPACE  = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_NOT_USED  = 3'd4,
    ST_ZERO      = 3'd5
  } status_e;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_e;

  typedef struct packed {
    logic        opcode;
    logic        heap_select;
    logic [30:0] request_bytes;
    logic [31:0] free_address;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] block_address;
  } rsp_t;

  typedef struct packed {
    logic clearing;
    logic busy;
  } ctl_stat_t;

endpackage

// ===== rtl/ffpa_ram.sv =====
module ffpa_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 8,
  parameter int AW = 12
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end
endmodule

// ===== rtl/ffpa_ctrl.sv =====
module ffpa_ctrl #(
  parameter int PAGES = 4096,
  parameter int AW = 12,
  parameter int CW = 13
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ffpa_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]                    cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  ffpa_pkg::req_t                 in_req_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output ffpa_pkg::rsp_t                 out_rsp_o,
  output logic                           m_we_o,
  output logic [AW-1:0]                  m_waddr_o,
  output logic [CW+1:0]                  m_wdata_o,
  output logic                           m_re_o,
  output logic [AW-1:0]                  m_raddr_o,
  input  logic [CW+1:0]                  m_rdata_i,
  output logic                           p_we_o,
  output logic [AW-1:0]                  p_waddr_o,
  output logic [AW-1:0]                  p_wdata_o,
  output logic                           p_re_o,
  output logic [AW-1:0]                  p_raddr_o,
  input  logic [AW-1:0]                  p_rdata_i,
  output ffpa_pkg::ctl_stat_t            stat_o
);
  import ffpa_pkg::*;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_A_ISS = 4'd2;
  localparam logic [3:0] S_A_CHK = 4'd3;
  localparam logic [3:0] S_A_W2  = 4'd4;
  localparam logic [3:0] S_F_CHK = 4'd5;
  localparam logic [3:0] S_F_NX  = 4'd6;
  localparam logic [3:0] S_F_NXW = 4'd7;
  localparam logic [3:0] S_F_PV  = 4'd8;
  localparam logic [3:0] S_F_PVD = 4'd9;
  localparam logic [3:0] S_F_PVM = 4'd10;
  localparam logic [3:0] S_F_PVW = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  logic [3:0]    st_q, st_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [31:0]   base_q, base_d;
  logic [CW-1:0] hp_q, hp_d;
  logic [CW-1:0] p_q, p_d;
  logic [CW-1:0] s_q, s_d;
  logic [AW-1:0] pv_q, pv_d;
  req_t          req_q, req_d;
  rsp_t          res_q, res_d;
  logic          ov_q, ov_d;
  rsp_t          out_q, out_d;

  logic [31:0]     need_sum;
  logic [NEED_W-1:0] need;
  logic [CW-1:0]   n_w;
  logic [31:0]     diff;
  logic [NEED_W-1:0] pg_w;
  logic [NEED_W-1:0] bpages;
  logic [CW-1:0]   r_pages;
  logic            r_used;
  logic            r_head;
  logic [CW-1:0]   sum_ps;
  logic [CW-1:0]   sum_pn;
  logic [31:0]     p_addr;

  assign r_pages = m_rdata_i[CW+1:2];
  assign r_used = m_rdata_i[1];
  assign r_head = m_rdata_i[0];
  assign need_sum = {1'b0, req_q.request_bytes} + 32'd4095;
  assign need = need_sum[31:PAGE_SHIFT];
  assign n_w = need[CW-1:0];
  assign diff = in_req_i.free_address - base_q;
  assign pg_w = diff[31:PAGE_SHIFT];
  assign bpages = cfg_data_i[31:PAGE_SHIFT];
  assign sum_ps = p_q + s_q;
  assign sum_pn = p_q + n_w;
  assign p_addr = base_q + (32'(p_q) << PAGE_SHIFT);

  assign in_stall_o = (st_q != S_IDLE);
  assign out_valid_o = ov_q;
  assign out_rsp_o = out_q;
  assign stat_o.clearing = (st_q == S_CLEAR);
  assign stat_o.busy = (st_q != S_IDLE);

  always_comb begin
    st_d = st_q;
    clr_d = clr_q;
    base_d = base_q;
    hp_d = hp_q;
    p_d = p_q;
    s_d = s_q;
    pv_d = pv_q;
    req_d = req_q;
    res_d = res_q;
    ov_d = ov_q;
    out_d = out_q;
    m_we_o = 1'b0;
    m_waddr_o = p_q[AW-1:0];
    m_wdata_o = '0;
    m_re_o = 1'b0;
    m_raddr_o = p_q[AW-1:0];
    p_we_o = 1'b0;
    p_waddr_o = sum_ps[AW-1:0];
    p_wdata_o = p_q[AW-1:0];
    p_re_o = 1'b0;
    p_raddr_o = p_q[AW-1:0];

    if (ov_q && !out_stall_i) begin
      ov_d = 1'b0;
    end

    unique case (st_q)
      S_CLEAR: begin
        m_we_o = 1'b1;
        m_waddr_o = clr_q;
        m_wdata_o = (clr_q == '0) ? {hp_q, 1'b0, 1'b1} : '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == AW'(PAGES - 1)) begin
          st_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          req_d = in_req_i;
          res_d.block_address = '0;
          p_d = '0;
          if (in_req_i.heap_select) begin
            res_d.status = ST_NO_HEAP;
            st_d = S_OUT;
          end else if (in_req_i.opcode == OP_ALLOC) begin
            if (in_req_i.request_bytes == '0) begin
              res_d.status = ST_ZERO;
              st_d = S_OUT;
            end else begin
              st_d = S_A_ISS;
            end
          end else if (diff[PAGE_SHIFT-1:0] != '0 || pg_w >= NEED_W'(hp_q)) begin
            res_d.status = ST_NOT_FOUND;
            st_d = S_OUT;
          end else begin
            p_d = pg_w[CW-1:0];
            m_re_o = 1'b1;
            m_raddr_o = pg_w[AW-1:0];
            st_d = S_F_CHK;
          end
        end
      end
      S_A_ISS: begin
        if (p_q >= hp_q) begin
          res_d.status = ST_NO_SPACE;
          st_d = S_OUT;
        end else begin
          m_re_o = 1'b1;
          st_d = S_A_CHK;
        end
      end
      S_A_CHK: begin
        if (r_pages == '0) begin
          res_d.status = ST_NO_SPACE;
          st_d = S_OUT;
        end else if (!r_used && NEED_W'(r_pages) >= need) begin
          s_d = r_pages;
          if (n_w < r_pages) begin
            m_we_o = 1'b1;
            m_waddr_o = sum_pn[AW-1:0];
            m_wdata_o = {r_pages - n_w, 1'b0, 1'b1};
            p_we_o = 1'b1;
            p_waddr_o = sum_pn[AW-1:0];
            p_wdata_o = p_q[AW-1:0];
            st_d = S_A_W2;
          end else begin
            m_we_o = 1'b1;
            m_wdata_o = {r_pages, 1'b1, 1'b1};
            res_d.status = ST_OK;
            res_d.block_address = p_addr;
            st_d = S_OUT;
          end
        end else begin
          p_d = p_q + r_pages;
          st_d = S_A_ISS;
        end
      end
      S_A_W2: begin
        m_we_o = 1'b1;
        m_wdata_o = {n_w, 1'b1, 1'b1};
        p_we_o = (sum_ps < hp_q);
        p_wdata_o = sum_pn[AW-1:0];
        res_d.status = ST_OK;
        res_d.block_address = p_addr;
        st_d = S_OUT;
      end
      S_F_CHK: begin
        s_d = r_pages;
        if (!r_head) begin
          res_d.status = ST_NOT_FOUND;
          st_d = S_OUT;
        end else if (!r_used) begin
          res_d.status = ST_NOT_USED;
          st_d = S_OUT;
        end else if ((p_q + r_pages) < hp_q) begin
          m_re_o = 1'b1;
          m_raddr_o = AW'(p_q + r_pages);
          st_d = S_F_NX;
        end else begin
          m_we_o = 1'b1;
          m_wdata_o = {r_pages, 1'b0, 1'b1};
          st_d = S_F_PV;
        end
      end
      S_F_NX: begin
        if (!r_used) begin
          m_we_o = 1'b1;
          m_waddr_o = sum_ps[AW-1:0];
          m_wdata_o = '0;
          s_d = s_q + r_pages;
          st_d = S_F_NXW;
        end else begin
          m_we_o = 1'b1;
          m_wdata_o = {s_q, 1'b0, 1'b1};
          st_d = S_F_PV;
        end
      end
      S_F_NXW: begin
        m_we_o = 1'b1;
        m_wdata_o = {s_q, 1'b0, 1'b1};
        p_we_o = (sum_ps < hp_q);
        st_d = S_F_PV;
      end
      S_F_PV: begin
        if (p_q == '0) begin
          res_d.status = ST_OK;
          st_d = S_OUT;
        end else begin
          p_re_o = 1'b1;
          st_d = S_F_PVD;
        end
      end
      S_F_PVD: begin
        pv_d = p_rdata_i;
        if (CW'(p_rdata_i) < p_q) begin
          m_re_o = 1'b1;
          m_raddr_o = p_rdata_i;
          st_d = S_F_PVM;
        end else begin
          res_d.status = ST_OK;
          st_d = S_OUT;
        end
      end
      S_F_PVM: begin
        if (!r_used) begin
          m_we_o = 1'b1;
          m_waddr_o = pv_q;
          m_wdata_o = {r_pages + s_q, 1'b0, 1'b1};
          st_d = S_F_PVW;
        end else begin
          res_d.status = ST_OK;
          st_d = S_OUT;
        end
      end
      S_F_PVW: begin
        m_we_o = 1'b1;
        m_wdata_o = '0;
        p_we_o = (sum_ps < hp_q);
        p_wdata_o = pv_q;
        res_d.status = ST_OK;
        st_d = S_OUT;
      end
      S_OUT: begin
        if (!ov_q || !out_stall_i) begin
          ov_d = 1'b1;
          out_d = res_q;
          st_d = S_IDLE;
        end
      end
      default: begin
        st_d = S_CLEAR;
        clr_d = '0;
      end
    endcase

    if (cfg_we_i) begin
      if (cfg_idx_i == REG_HEAP_BASE) begin
        base_d = cfg_data_i;
      end else begin
        hp_d = (bpages > NEED_W'(PAGES)) ? CW'(PAGES) : bpages[CW-1:0];
      end
      st_d = S_CLEAR;
      clr_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_CLEAR;
      clr_q <= '0;
      base_q <= '0;
      hp_q <= '0;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      clr_q <= clr_d;
      base_q <= base_d;
      hp_q <= hp_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
    s_q <= s_d;
    pv_q <= pv_d;
    req_q <= req_d;
    res_q <= res_d;
    out_q <= out_d;
  end
endmodule

// ===== rtl/first_fit_page_allocator_top.sv =====
// First-fit page allocator for one heap of 4 KiB pages, with coalescing on free.
// Requests arrive on in_req_i under in_valid_i and are taken when in_stall_o is
// low; one response per request leaves on out_rsp_o under out_valid_o and is
// taken when out_stall_i is low. Requests are handled one at a time.
// An allocate walks the block table block by block through the block memory's
// read port, issuing each read in S_A_ISS and checking the block in S_A_CHK; a
// split writes the headers of both parts, in S_A_CHK and S_A_W2.
// A free reads the block memory for the freed block and its neighbours, and
// the back-link memory for the preceding block.
// The response register is loaded in S_OUT when it is empty or being taken; a
// new request is accepted while that response still waits, and the next
// response waits in turn while the receiver stalls.
// Reset, and any write on the configuration port, starts a clearing pass that
// rebuilds the heap as a single free block; no request is accepted during the
// pass. Configuration is to be written only while the block is idle; the
// block itself does not enforce this.
module first_fit_page_allocator_top #(
  parameter int PAGES = ffpa_pkg::FFPA_PAGES
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ffpa_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]                    cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  ffpa_pkg::req_t                 in_req_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output ffpa_pkg::rsp_t                 out_rsp_o
);
  import ffpa_pkg::*;

  localparam int AW = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int CW = $clog2(PAGES + 1);

  logic          m_we, m_re, p_we, p_re;
  logic [AW-1:0] m_waddr, m_raddr, p_waddr, p_raddr, p_wdata, p_rdata;
  logic [CW+1:0] m_wdata, m_rdata;
  ctl_stat_t     stat;

  ffpa_ram #(.DEPTH(PAGES), .WIDTH(CW + 2), .AW(AW)) u_meta (
    .clk_i, .we_i(m_we), .waddr_i(m_waddr), .wdata_i(m_wdata),
    .re_i(m_re), .raddr_i(m_raddr), .rdata_o(m_rdata)
  );

  ffpa_ram #(.DEPTH(PAGES), .WIDTH(AW), .AW(AW)) u_prev (
    .clk_i, .we_i(p_we), .waddr_i(p_waddr), .wdata_i(p_wdata),
    .re_i(p_re), .raddr_i(p_raddr), .rdata_o(p_rdata)
  );

  ffpa_ctrl #(.PAGES(PAGES), .AW(AW), .CW(CW)) u_ctrl (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .in_req_i,
    .out_valid_o, .out_stall_i, .out_rsp_o,
    .m_we_o(m_we), .m_waddr_o(m_waddr), .m_wdata_o(m_wdata),
    .m_re_o(m_re), .m_raddr_o(m_raddr), .m_rdata_i(m_rdata),
    .p_we_o(p_we), .p_waddr_o(p_waddr), .p_wdata_o(p_wdata),
    .p_re_o(p_re), .p_raddr_o(p_raddr), .p_rdata_i(p_rdata),
    .stat_o(stat)
  );

`include "first_fit_page_allocator_top_assert.svh"

  `FFPA_ASSERT_SAME(a_no_accept_clear, stat.clearing, in_stall_o)
  `FFPA_ASSERT_SAME(a_meta_no_rw_clash, m_we && m_re, m_waddr != m_raddr)
  `FFPA_ASSERT_NEXT(a_cfg_rebuilds, cfg_we_i, stat.clearing)
  `FFPA_ASSERT_NEXT(a_out_held, out_valid_o && out_stall_i, out_valid_o)

endmodule

// ===== dv/first_fit_page_allocator_top_test.sv =====
module first_fit_page_allocator_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ffpa_pkg::*;

  localparam int NPAGES = FFPA_PAGES;

  class heap_scoreboard;
    logic [31:0] base_addr;
    logic [31:0] size_bytes;
    int unsigned npages_live;
    int unsigned blk_len[NPAGES];
    bit blk_used[NPAGES];
    bit blk_head[NPAGES];
    int unsigned blk_prev[NPAGES];
    rsp_t expected_q[$];
    logic [31:0] live_addrs[$];
    logic [31:0] freed_addrs[$];
    int mismatches;

    function new();
      base_addr = '0;
      size_bytes = '0;
      mismatches = 0;
      rebuild();
    endfunction

    function void rebuild();
      int unsigned n;
      n = size_bytes >> PAGE_SHIFT;
      if (n > NPAGES) n = NPAGES;
      npages_live = n;
      foreach (blk_len[i]) begin
        blk_len[i] = 0;
        blk_used[i] = 0;
        blk_head[i] = 0;
        blk_prev[i] = 0;
      end
      blk_head[0] = 1;
      blk_len[0] = n;
      live_addrs.delete();
      freed_addrs.delete();
    endfunction

    function void configure(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
      if (idx == REG_HEAP_BASE) base_addr = value;
      else size_bytes = value;
      rebuild();
    endfunction

    function status_e allocate(logic [30:0] nbytes, output logic [31:0] addr);
      longint unsigned need;
      int unsigned p;
      int unsigned s;
      int unsigned q;
      addr = '0;
      if (nbytes == 0) return ST_ZERO;
      need = (longint'(nbytes) + 4095) >> PAGE_SHIFT;
      p = 0;
      while (p < npages_live) begin
        s = blk_len[p];
        if (s == 0) break;
        if (!blk_used[p] && s >= need) begin
          if (need < s) begin
            q = p + int'(need);
            blk_head[q] = 1;
            blk_used[q] = 0;
            blk_len[q] = s - int'(need);
            blk_prev[q] = p;
            if (p + s < npages_live) blk_prev[p + s] = q;
            blk_len[p] = int'(need);
          end
          blk_used[p] = 1;
          addr = base_addr + (p << PAGE_SHIFT);
          return ST_OK;
        end
        p += s;
      end
      return ST_NO_SPACE;
    endfunction

    function status_e release_block(logic [31:0] addr);
      logic [31:0] diff;
      int unsigned pg;
      int unsigned s;
      int unsigned nx;
      int unsigned pv;
      diff = addr - base_addr;
      if (diff[PAGE_SHIFT-1:0] != 0) return ST_NOT_FOUND;
      if ((diff >> PAGE_SHIFT) >= npages_live) return ST_NOT_FOUND;
      pg = diff >> PAGE_SHIFT;
      if (!blk_head[pg]) return ST_NOT_FOUND;
      if (!blk_used[pg]) return ST_NOT_USED;
      blk_used[pg] = 0;
      s = blk_len[pg];
      nx = pg + s;
      if (nx < npages_live && !blk_used[nx]) begin
        s += blk_len[nx];
        blk_head[nx] = 0;
        blk_len[nx] = 0;
        blk_len[pg] = s;
        if (pg + s < npages_live) blk_prev[pg + s] = pg;
      end
      if (pg != 0) begin
        pv = blk_prev[pg];
        if (pv < pg && !blk_used[pv]) begin
          blk_len[pv] += s;
          blk_head[pg] = 0;
          blk_len[pg] = 0;
          if (pg + s < npages_live) blk_prev[pg + s] = pv;
        end
      end
      return ST_OK;
    endfunction

    function void note_request(req_t r);
      rsp_t e;
      logic [31:0] a;
      a = '0;
      if (r.heap_select) e.status = ST_NO_HEAP;
      else if (r.opcode == OP_ALLOC) begin
        e.status = allocate(r.request_bytes, a);
        if (e.status == ST_OK) live_addrs.push_back(a);
      end else begin
        e.status = release_block(r.free_address);
        if (e.status == ST_OK) begin
          foreach (live_addrs[i])
            if (live_addrs[i] == r.free_address) begin
              live_addrs.delete(i);
              break;
            end
          freed_addrs.push_back(r.free_address);
        end
      end
      e.block_address = (e.status == ST_OK && r.opcode == OP_ALLOC) ? a : '0;
      expected_q.push_back(e);
    endfunction

    function void check_response(rsp_t got);
      rsp_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected response status=%0d addr=%h", got.status,
                   got.block_address);
        return;
      end
      e = expected_q.pop_front();
      if (got.status !== e.status || got.block_address !== e.block_address) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: response mismatch: expected status=%0d addr=%h, got status=%0d addr=%h",
                   e.status, e.block_address, got.status, got.block_address);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [31:0] cfg_data_i;
  logic in_valid_i;
  logic in_stall_o;
  req_t in_req_i;
  logic out_valid_o;
  logic out_stall_i;
  rsp_t out_rsp_o;

  heap_scoreboard sb;
  bit quiet;
  int responses_seen;

  first_fit_page_allocator_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #400ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_request(req_t r);
    int gap;
    in_valid_i <= 1'b1;
    in_req_i <= r;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(r);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.configure(idx, value);
    repeat (NPAGES + 16) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_heap(logic [31:0] base, logic [31:0] nbytes);
    drain();
    write_register(REG_HEAP_BASE, base);
    write_register(REG_HEAP_BYTES, nbytes);
  endtask

  function automatic req_t make_req(logic op, logic sel, logic [30:0] nbytes, logic [31:0] a);
    req_t r;
    r.opcode = op;
    r.heap_select = sel;
    r.request_bytes = nbytes;
    r.free_address = a;
    return r;
  endfunction

  function automatic req_t random_req();
    int r;
    logic [31:0] a;
    r = $urandom_range(0, 99);
    a = $urandom;
    if (r < 3) return make_req(1'($urandom_range(0, 1)), 1'b1, 31'($urandom), a);
    if (r < 5) return make_req(OP_ALLOC, 1'b0, '0, a);
    if (r < 9) return make_req(OP_ALLOC, 1'b0, 31'($urandom), a);
    if (r < 50) return make_req(OP_ALLOC, 1'b0, 31'($urandom_range(1, 6 * 4096)), a);
    if (r < 82 && sb.live_addrs.size() > 0)
      a = sb.live_addrs[$urandom_range(0, sb.live_addrs.size() - 1)];
    else if (r < 89 && sb.freed_addrs.size() > 0)
      a = sb.freed_addrs[$urandom_range(0, sb.freed_addrs.size() - 1)];
    else if (r < 95 && sb.live_addrs.size() > 0)
      a = sb.live_addrs[$urandom_range(0, sb.live_addrs.size() - 1)] +
          $urandom_range(1, 3 * 4096);
    return make_req(OP_FREE, 1'b0, 31'($urandom), a);
  endfunction

  task automatic random_phase(int count);
    repeat (count) begin
      quiet = ($urandom_range(0, 7) == 0) ? ~quiet : quiet;
      send_request(random_req());
    end
    quiet = 1'b0;
  endtask

  always @(posedge clk_i) begin : response_side
    static int hold = 0;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_response(out_rsp_o);
      responses_seen++;
      if (responses_seen == 300) hold = 3000;
    end
    if (hold > 0) begin
      hold--;
      out_stall_i <= 1'b1;
    end else if (quiet) begin
      out_stall_i <= 1'b0;
    end else begin
      case ($urandom_range(0, 99)) inside
        [0:69]: out_stall_i <= 1'b0;
        [70:96]: out_stall_i <= 1'b1;
        default: hold = $urandom_range(10, 40);
      endcase
    end
  end

  initial begin
    req_t r;
    sb = new();
    quiet = 1'b0;
    responses_seen = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    in_req_i = '0;
    out_stall_i = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(make_req(OP_ALLOC, 1'b0, 31'd4096, '0));
    send_request(make_req(OP_FREE, 1'b0, '0, '0));

    set_heap(32'h0000_1000, 32'd8 * 4096 + 5);
    send_request(make_req(OP_ALLOC, 1'b0, '0, '1));
    send_request(make_req(OP_ALLOC, 1'b1, 31'd100, '0));
    send_request(make_req(OP_FREE, 1'b1, '1, 32'h0000_1000));
    send_request(make_req(OP_ALLOC, 1'b0, 31'd1, '0));
    send_request(make_req(OP_ALLOC, 1'b0, 31'd4096, '0));
    send_request(make_req(OP_ALLOC, 1'b0, 31'd4097, '0));
    send_request(make_req(OP_ALLOC, 1'b0, '1, '0));
    send_request(make_req(OP_FREE, 1'b0, '0, 32'h0000_1001));
    send_request(make_req(OP_FREE, 1'b0, '0, 32'h0000_0000));
    send_request(make_req(OP_FREE, 1'b0, '0, 32'h0000_9000));
    send_request(make_req(OP_FREE, 1'b0, '0, 32'h0000_4000));
    send_request(make_req(OP_FREE, 1'b0, '0, '1));
    send_request(make_req(OP_FREE, 1'b0, '0, 32'h0000_1000));
    send_request(make_req(OP_FREE, 1'b0, '0, 32'h0000_1000));
    send_request(make_req(OP_FREE, 1'b0, '0, 32'h0000_2000));
    send_request(make_req(OP_ALLOC, 1'b0, 31'd12288, '0));
    send_request(make_req(OP_ALLOC, 1'b0, 31'd20480, '0));
    send_request(make_req(OP_ALLOC, 1'b0, 31'd1, '0));
    send_request(make_req(OP_FREE, 1'b0, '0, 32'h0000_3000));
    send_request(make_req(OP_FREE, 1'b0, '0, 32'h0000_4000));
    send_request(make_req(OP_FREE, 1'b0, '0, 32'h0000_1000));
    send_request(make_req(OP_ALLOC, 1'b0, 31'd32768, '0));

    random_phase(150);

    set_heap(32'hFFFF_E000, 32'hFFFF_FFFF);
    random_phase(450);

    set_heap($urandom & 32'hFFFF_FFFE, $urandom_range(4096, 64 * 4096));
    random_phase(400);

    set_heap($urandom & 32'hFFFF_FFFE, 32'd3 * 4096 + 1);
    random_phase(200);

    set_heap(32'hFFFF_FFFE, $urandom);
    random_phase(230);

    drain();
    if (sb.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// ===== first_fit_page_allocator_top.f =====
+incdir+rtl
rtl/ffpa_pkg.sv
rtl/ffpa_ram.sv
rtl/ffpa_ctrl.sv
rtl/first_fit_page_allocator_top.sv
dv/first_fit_page_allocator_top_test.sv
